### rtl/core/fcw_pkg.sv
// shared types and constants for the fat12 cluster chain walker
package fcw_pkg;

    localparam int CLUSTER_W  = 12;
    localparam int OFFSET_W   = 13;
    localparam int BYTE_W     = 8;
    localparam int SECTOR_W   = 32;
    localparam int PRODUCT_W  = 20;
    localparam int DSTART_W   = 25;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 48;
    localparam int FUNC_W     = 2;

    localparam logic [CLUSTER_W-1:0] END_MARK      = 12'hFF8;
    localparam logic [CLUSTER_W-1:0] FIRST_CLUSTER = 12'd2;
    localparam logic [BYTE_W-1:0]    HIGH_NIBBLE   = 8'hF0;
    localparam logic [BYTE_W-1:0]    LOW_NIBBLE    = 8'h0F;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD    = 2'd0,
        FUNC_START   = 2'd1,
        FUNC_ADVANCE = 2'd2
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SECTORS_PER_CLUSTER = 3'd0,
        CFG_RESERVED_SECTORS    = 3'd1,
        CFG_FAT_COPIES          = 3'd2,
        CFG_SECTORS_PER_TABLE   = 3'd3,
        CFG_ROOT_DIR_SECTORS    = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic                en;
        logic [OFFSET_W-1:0] addr;
        logic [BYTE_W-1:0]   data;
    } wr_req_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] addr_lo;
        logic [OFFSET_W-1:0] addr_hi;
    } rd_req_t;

endpackage

### rtl/core/fat12_cluster_chain_walker_top.sv
// top level of the fat12 cluster chain walker
//
//  channel  direction  transfer when            contents
//  s_*      in         s_tvalid && s_tready     tuser func, tdata offset/byte/start cluster
//  m_*      out        m_tvalid && m_tready     tdata cluster/sector, tlast end, tuser bad
//  cfg_*    in         cfg_valid && cfg_ready   register index and write data
//
// a load or an unused func ends on acceptance; a start or an advance on an ended
// chain passes through the emit state; an advance on a live chain passes accept with
// table read, unpack and result, since the byte store's read ports are registered.
// one item is in flight at a time; the result register lets the next item in
// while a result still waits. a result stalls in place while m_tready is low.
// reset ends the chain and puts the config registers to their defaults.
module fat12_cluster_chain_walker_top #(
    parameter int TABLE_BYTES = 8192
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [12:0] table_offset, [20:13] table_byte, [32:21] start_cluster, rest zero
    input  logic [fcw_pkg::S_TDATA_W-1:0]       s_tdata,
    // [1:0] func
    input  logic [fcw_pkg::FUNC_W-1:0]          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [11:0] cluster, [43:12] sector_lba, rest zero
    output logic [fcw_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                m_tlast,
    // [0] bad_start
    output logic [0:0]                          m_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fcw_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fcw_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import fcw_pkg::*;

    // config registers
    logic [7:0]          spc_reg;
    logic [15:0]         reserved_reg;
    logic [7:0]          copies_reg;
    logic [15:0]         spt_reg;
    logic [15:0]         root_reg;
    logic [DSTART_W-1:0] dstart_reg;

    // chain state
    state_t               state_reg, state_next;
    logic [CLUSTER_W-1:0] cluster_reg, cluster_next;
    logic                 ended_reg, ended_next;
    logic                 was_ended_reg, was_ended_next;
    logic [1:0]           rd_ok_reg;

    // result register
    logic                 out_valid_reg;
    logic [CLUSTER_W-1:0] out_cluster_reg;
    logic [SECTOR_W-1:0]  out_sector_reg;
    logic                 out_end_reg;
    logic                 out_bad_reg;

    logic                 in_xfer;
    logic                 slot_free;
    logic                 emit_go;
    func_t                func;
    logic [OFFSET_W-1:0]  in_offset;
    logic [BYTE_W-1:0]    in_byte;
    logic [CLUSTER_W-1:0] in_start;

    wr_req_t              wr;
    rd_req_t              rd;
    logic [OFFSET_W-1:0]  entry_off;
    logic [BYTE_W-1:0]    rd_data_lo, rd_data_hi;
    logic [BYTE_W-1:0]    b0, b1;
    logic [CLUSTER_W-1:0] entry;

    logic                 emit_end, emit_bad;
    logic [PRODUCT_W-1:0] product;
    logic [SECTOR_W-1:0]  sector;

    assign func      = func_t'(s_tuser);
    assign in_offset = s_tdata[12:0];
    assign in_byte   = s_tdata[20:13];
    assign in_start  = s_tdata[32:21];
    assign in_xfer   = s_tvalid && s_tready;
    assign slot_free = !out_valid_reg || m_tready;
    assign cfg_ready = 1'b1;

    // table store
    assign wr.en   = in_xfer && (func == FUNC_LOAD) && (32'(in_offset) < 32'(TABLE_BYTES));
    assign wr.addr = in_offset;
    assign wr.data = in_byte;

    // entry sits at c + c/2
    assign entry_off  = OFFSET_W'(cluster_reg) + OFFSET_W'(cluster_reg[CLUSTER_W-1:1]);
    assign rd.addr_lo = entry_off;
    assign rd.addr_hi = entry_off + OFFSET_W'(1);

    fcw_table_ram #(
        .DEPTH (TABLE_BYTES)
    ) u_ram (
        .clk        (clk),
        .wr         (wr),
        .rd         (rd),
        .rd_data_lo (rd_data_lo),
        .rd_data_hi (rd_data_hi)
    );

    // bytes past the end of the store read as zero
    always_ff @(posedge clk)
    begin
        rd_ok_reg[0] <= 32'(rd.addr_lo) < 32'(TABLE_BYTES);
        rd_ok_reg[1] <= 32'(rd.addr_hi) < 32'(TABLE_BYTES);
    end

    assign b0 = rd_ok_reg[0] ? rd_data_lo : '0;
    assign b1 = rd_ok_reg[1] ? rd_data_hi : '0;

    always_comb
    begin
        if (cluster_reg[0])
        begin
            entry = {b1, 4'((b0 & HIGH_NIBBLE) >> 4)};
        end
        else
        begin
            entry = {4'(b1 & LOW_NIBBLE), b0};
        end
    end

    // config port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spc_reg      <= 8'd1;
            reserved_reg <= 16'd1;
            copies_reg   <= 8'd2;
            spt_reg      <= 16'd9;
            root_reg     <= 16'd14;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_SECTORS_PER_CLUSTER: spc_reg      <= cfg_data[7:0];
                CFG_RESERVED_SECTORS:    reserved_reg <= cfg_data;
                CFG_FAT_COPIES:          copies_reg   <= cfg_data[7:0];
                CFG_SECTORS_PER_TABLE:   spt_reg      <= cfg_data;
                CFG_ROOT_DIR_SECTORS:    root_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // first data sector, refreshed every cycle from the config registers
    always_ff @(posedge clk)
    begin
        dstart_reg <= DSTART_W'(reserved_reg) + DSTART_W'(copies_reg) * DSTART_W'(spt_reg)
                    + DSTART_W'(root_reg);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && func == FUNC_START)
                begin
                    state_next = ST_EMIT;
                end
                else if (in_xfer && func == FUNC_ADVANCE)
                begin
                    state_next = ended_reg ? ST_EMIT : ST_READ;
                end
            end
            ST_READ: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb
    begin
        s_tready = 1'b0;
        emit_go  = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_READ: ;
            ST_EMIT: emit_go = slot_free;
            default: ;
        endcase
    end

    // chain state update
    always_comb
    begin
        cluster_next   = cluster_reg;
        ended_next     = ended_reg;
        was_ended_next = was_ended_reg;
        if (in_xfer && func == FUNC_START)
        begin
            cluster_next   = in_start;
            ended_next     = (in_start < FIRST_CLUSTER) || (in_start >= END_MARK);
            was_ended_next = 1'b0;
        end
        else if (in_xfer && func == FUNC_ADVANCE)
        begin
            was_ended_next = ended_reg;
        end
        else if (state_reg == ST_READ)
        begin
            cluster_next = entry;
            ended_next   = (entry < FIRST_CLUSTER) || (entry >= END_MARK);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cluster_reg   <= '0;
            ended_reg     <= 1'b1;
            was_ended_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cluster_reg   <= cluster_next;
            ended_reg     <= ended_next;
            was_ended_reg <= was_ended_next;
        end
    end

    // result
    assign emit_end = was_ended_reg || (cluster_reg >= END_MARK);
    assign emit_bad = cluster_reg < FIRST_CLUSTER;
    assign product  = PRODUCT_W'(cluster_reg - FIRST_CLUSTER) * PRODUCT_W'(spc_reg);
    assign sector   = (emit_end || emit_bad) ? '0
                    : SECTOR_W'(dstart_reg) + SECTOR_W'(product);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_go)
        begin
            out_cluster_reg <= cluster_reg;
            out_sector_reg  <= sector;
            out_end_reg     <= emit_end;
            out_bad_reg     <= emit_bad;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_sector_reg, out_cluster_reg};
    assign m_tlast  = out_end_reg;
    assign m_tuser  = out_bad_reg;

endmodule

### rtl/core/fcw_table_ram.sv
// byte store for the allocation table: one write port, two registered read ports
module fcw_table_ram #(
    parameter int DEPTH = 8192
) (
    input  logic                             clk,
    input  fcw_pkg::wr_req_t                 wr,
    input  fcw_pkg::rd_req_t                 rd,
    output logic [fcw_pkg::BYTE_W-1:0]       rd_data_lo,
    output logic [fcw_pkg::BYTE_W-1:0]       rd_data_hi
);
    import fcw_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [BYTE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[AW'(wr.addr)] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_lo <= mem[AW'(rd.addr_lo)];
        rd_data_hi <= mem[AW'(rd.addr_hi)];
    end

endmodule

### rtl/core/fcw_checker.sv
// port-level checks for the fat12 cluster chain walker, bound to the top level
module fcw_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [fcw_pkg::FUNC_W-1:0]     s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [fcw_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                           m_tlast,
    input logic [0:0]                     m_tuser
);
    import fcw_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("result changed while stalled");

    // ended or bad clusters carry no sector
    a_no_sector: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tlast || m_tuser[0]) |-> m_tdata[43:12] == '0)
        else $error("sector reported for ended or bad cluster");

    // end marker always raises end of chain
    a_end_mark: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[11:0] >= END_MARK) |-> m_tlast)
        else $error("end marker without end of chain");

    // bad flag follows the cluster value exactly
    a_bad_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser[0] == (m_tdata[11:0] < FIRST_CLUSTER))
        else $error("bad flag does not match cluster");

    // a load transfer never produces a result in the following cycle from idle
    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == FUNC_LOAD) && !m_tvalid |=> !m_tvalid)
        else $error("result after a table load");

endmodule

bind fat12_cluster_chain_walker_top fcw_checker u_fcw_checker (.*);
